@@ design/tcp_connection_tracker_assert.svh @@
// Assertion helpers for the connection tracker, clocked on clk and quiet in reset.
`ifndef TCP_CONNECTION_TRACKER_ASSERT_SVH
`define TCP_CONNECTION_TRACKER_ASSERT_SVH

`define TCT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define TCT_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/tct_pkg.sv @@
`timescale 1ns / 1ps
package tct_pkg;

    localparam int FLOW_ENTRIES_DEF = 64;
    localparam int IDX_W            = 6;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] TCP_PROTOCOL = 8'd6;
    localparam logic [3:0] MIN_WORDS    = 4'd5;
    localparam int FLAG_FIN_BIT = 0;
    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_RST_BIT = 2;

    localparam logic [2:0] V_NONTCP   = 3'd0;
    localparam logic [2:0] V_FILTERED = 3'd1;
    localparam logic [2:0] V_BAD_HDR  = 3'd2;
    localparam logic [2:0] V_NO_CONN  = 3'd3;
    localparam logic [2:0] V_EXISTING = 3'd4;
    localparam logic [2:0] V_OPENED   = 3'd5;
    localparam logic [2:0] V_FULL     = 3'd6;

    localparam logic CFG_FILTER_ENABLE = 1'b0;
    localparam logic CFG_FILTER_ADDR   = 1'b1;

    typedef enum logic [2:0] {
        K_FILTERED,
        K_NONTCP,
        K_BAD_HDR,
        K_SYN,
        K_OTHER
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic        close;
        logic        short_hdr;
    } item_t;

    typedef struct packed {
        logic [31:0]      conn;
        logic [31:0]      nontcp;
        logic [31:0]      tcp;
        logic             short_hdr;
        logic             closed;
        logic [IDX_W-1:0] idx;
        logic [31:0]      flow;
        logic [2:0]       verdict;
    } result_t;

endpackage

@@ design/tcp_connection_tracker.sv @@
`timescale 1ns / 1ps
// TCP connection tracker: one packet header per beat in, one verdict beat out.
// Non-table packets (filtered, non-TCP, bad TCP header) go straight to the result state;
// SYN, FIN, RST and other TCP packets search the connection table one entry per
// cycle through its single read port, ending early at the first matching entry.
// A two-beat queue sits between the input classifier and the table engine, and the
// output is registered, so input beats are taken while a result waits.
module tcp_connection_tracker
    import tct_pkg::*;
#(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // src_addr, dst_addr, src_port, dst_port, protocol, ip_header_words,
    // tcp_header_words, tcp_flags
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // verdict, flow_number, entry_index, connection_closed, short_ip_header,
    // tcp_packets, nontcp_packets, connections_opened, zero fill
    output logic [143:0] m_tdata
);

    logic    push;
    item_t   push_item;
    logic    full;
    logic    pop;
    logic    q_valid;
    item_t   q_item;
    result_t result;

    tct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .full      (full),
        .in_ready  (s_tready),
        .push      (push),
        .push_item (push_item)
    );

    tct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .valid     (q_valid),
        .item      (q_item)
    );

    tct_back #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {5'd0, result};

endmodule

@@ design/tct_front.sv @@
`timescale 1ns / 1ps
module tct_front
    import tct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         in_valid,
    input  logic [119:0] in_data,
    input  logic         full,
    output logic         in_ready,
    output logic         push,
    output item_t        push_item
);

    logic        filter_en_reg;
    logic [31:0] filter_addr_reg;
    logic [31:0] sa;
    logic [7:0]  proto;
    logic [7:0]  flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_en_reg   <= 1'b0;
            filter_addr_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER_ENABLE: filter_en_reg   <= cfg_data[0];
                CFG_FILTER_ADDR:   filter_addr_reg <= cfg_data;
                default:           filter_en_reg   <= filter_en_reg;
            endcase
        end
    end

    assign sa    = in_data[31:0];
    assign proto = in_data[103:96];
    assign flags = in_data[119:112];

    assign in_ready = !full;
    assign push     = in_valid && !full;

    always_comb
    begin
        push_item.sa        = sa;
        push_item.da        = in_data[63:32];
        push_item.sp        = in_data[79:64];
        push_item.dp        = in_data[95:80];
        push_item.close     = flags[FLAG_FIN_BIT] | flags[FLAG_RST_BIT];
        push_item.short_hdr = in_data[107:104] < MIN_WORDS;
        if (filter_en_reg && (proto != TCP_PROTOCOL || sa != filter_addr_reg))
            push_item.kind = K_FILTERED;
        else if (proto != TCP_PROTOCOL)
            push_item.kind = K_NONTCP;
        else if (in_data[111:108] < MIN_WORDS)
            push_item.kind = K_BAD_HDR;
        else if (flags[FLAG_SYN_BIT])
            push_item.kind = K_SYN;
        else
            push_item.kind = K_OTHER;
    end

endmodule

@@ design/tct_queue.sv @@
`timescale 1ns / 1ps
module tct_queue
    import tct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output item_t item
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t         slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = count_reg == CW'(QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ design/tct_back.sv @@
`timescale 1ns / 1ps
module tct_back
    import tct_pkg::*;
#(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    localparam int IW = $clog2(FLOW_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT
    } state_t;

    logic [31:0] mem_sa [FLOW_ENTRIES];
    logic [31:0] mem_da [FLOW_ENTRIES];
    logic [31:0] mem_pp [FLOW_ENTRIES];
    logic [1:0]  mem_cc [FLOW_ENTRIES];
    logic [31:0] mem_fn [FLOW_ENTRIES];

    state_t                  state_reg;
    item_t                   cur_reg;
    logic [FLOW_ENTRIES-1:0] valid_reg;
    logic [IW-1:0]           addr_reg;
    logic                    issue_done_reg;
    logic                    rd_live_reg;
    logic [IW-1:0]           rd_idx_reg;
    logic [31:0]             rd_sa_reg;
    logic [31:0]             rd_da_reg;
    logic [31:0]             rd_pp_reg;
    logic [1:0]              rd_cc_reg;
    logic [31:0]             rd_fn_reg;
    logic                    free_found_reg;
    logic [IW-1:0]           free_idx_reg;
    logic                    hit_reg;
    logic [IW-1:0]           hit_idx_reg;
    logic [31:0]             hit_fn_reg;
    logic [1:0]              hit_cc_reg;
    logic [31:0]             conn_cnt_reg;
    logic [31:0]             tcp_cnt_reg;
    logic [31:0]             nontcp_cnt_reg;
    logic                    out_valid_reg;
    result_t                 out_reg;

    logic        match;
    logic        out_free;
    logic        act_fire;
    logic        open_we;
    logic        cc_we;
    logic [1:0]  cc_next;
    logic        close_now;
    result_t     res_next;
    logic [31:0] conn_cnt_next;
    logic [31:0] tcp_cnt_next;
    logic [31:0] nontcp_cnt_next;

    assign match = valid_reg[rd_idx_reg]
        && ((rd_sa_reg == cur_reg.sa && rd_da_reg == cur_reg.da
             && rd_pp_reg == {cur_reg.sp, cur_reg.dp})
         || (rd_sa_reg == cur_reg.da && rd_da_reg == cur_reg.sa
             && rd_pp_reg == {cur_reg.dp, cur_reg.sp}));

    assign out_free   = !out_valid_reg || out_ready;
    assign act_fire   = state_reg == ST_ACT && out_free;
    assign pop        = state_reg == ST_IDLE && q_valid;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign cc_next    = hit_cc_reg + 2'd1;

    always_comb
    begin
        res_next           = '0;
        res_next.short_hdr = cur_reg.short_hdr;
        conn_cnt_next      = conn_cnt_reg;
        tcp_cnt_next       = tcp_cnt_reg;
        nontcp_cnt_next    = nontcp_cnt_reg;
        open_we            = 1'b0;
        cc_we              = 1'b0;
        close_now          = 1'b0;
        case (cur_reg.kind)
            K_FILTERED:
                res_next.verdict = V_FILTERED;
            K_NONTCP:
            begin
                res_next.verdict = V_NONTCP;
                nontcp_cnt_next  = nontcp_cnt_reg + 32'd1;
            end
            K_BAD_HDR:
            begin
                res_next.verdict = V_BAD_HDR;
                tcp_cnt_next     = tcp_cnt_reg + 32'd1;
            end
            K_SYN:
            begin
                tcp_cnt_next = tcp_cnt_reg + 32'd1;
                if (hit_reg)
                begin
                    res_next.verdict = V_EXISTING;
                    res_next.flow    = hit_fn_reg;
                    res_next.idx     = IDX_W'(hit_idx_reg);
                end
                else if (free_found_reg)
                begin
                    res_next.verdict = V_OPENED;
                    res_next.flow    = conn_cnt_reg;
                    res_next.idx     = IDX_W'(free_idx_reg);
                    conn_cnt_next    = conn_cnt_reg + 32'd1;
                    open_we          = 1'b1;
                end
                else
                    res_next.verdict = V_FULL;
            end
            default:
            begin
                tcp_cnt_next = tcp_cnt_reg + 32'd1;
                if (hit_reg)
                begin
                    res_next.verdict = V_EXISTING;
                    res_next.flow    = hit_fn_reg;
                    res_next.idx     = IDX_W'(hit_idx_reg);
                    if (cur_reg.close)
                    begin
                        cc_we           = 1'b1;
                        close_now       = cc_next[1];
                        res_next.closed = cc_next[1];
                    end
                end
                else
                    res_next.verdict = V_NO_CONN;
            end
        endcase
        res_next.tcp    = tcp_cnt_next;
        res_next.nontcp = nontcp_cnt_next;
        res_next.conn   = conn_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rd_sa_reg <= mem_sa[addr_reg];
        rd_da_reg <= mem_da[addr_reg];
        rd_pp_reg <= mem_pp[addr_reg];
        rd_cc_reg <= mem_cc[addr_reg];
        rd_fn_reg <= mem_fn[addr_reg];
        if (act_fire && open_we)
        begin
            mem_sa[free_idx_reg] <= cur_reg.sa;
            mem_da[free_idx_reg] <= cur_reg.da;
            mem_pp[free_idx_reg] <= {cur_reg.sp, cur_reg.dp};
            mem_cc[free_idx_reg] <= 2'd0;
            mem_fn[free_idx_reg] <= conn_cnt_reg;
        end
        if (act_fire && cc_we)
            mem_cc[hit_idx_reg] <= cc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            valid_reg      <= '0;
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_live_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            hit_fn_reg     <= '0;
            hit_cc_reg     <= '0;
            conn_cnt_reg   <= '0;
            tcp_cnt_reg    <= '0;
            nontcp_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg        <= q_item;
                        addr_reg       <= '0;
                        issue_done_reg <= 1'b0;
                        rd_live_reg    <= 1'b0;
                        free_found_reg <= 1'b0;
                        hit_reg        <= 1'b0;
                        if (q_item.kind == K_SYN || q_item.kind == K_OTHER)
                            state_reg <= ST_SCAN;
                        else
                            state_reg <= ST_ACT;
                    end
                end
                ST_SCAN:
                begin
                    if (!issue_done_reg)
                    begin
                        rd_idx_reg     <= addr_reg;
                        rd_live_reg    <= 1'b1;
                        addr_reg       <= addr_reg + 1'b1;
                        issue_done_reg <= addr_reg == IW'(FLOW_ENTRIES - 1);
                    end
                    else
                        rd_live_reg <= 1'b0;
                    if (rd_live_reg)
                    begin
                        if (!valid_reg[rd_idx_reg] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= rd_idx_reg;
                        end
                        if (match)
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= rd_idx_reg;
                            hit_fn_reg  <= rd_fn_reg;
                            hit_cc_reg  <= rd_cc_reg;
                            state_reg   <= ST_ACT;
                        end
                        else if (rd_idx_reg == IW'(FLOW_ENTRIES - 1))
                            state_reg <= ST_ACT;
                    end
                end
                ST_ACT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_reg        <= res_next;
                        conn_cnt_reg   <= conn_cnt_next;
                        tcp_cnt_reg    <= tcp_cnt_next;
                        nontcp_cnt_reg <= nontcp_cnt_next;
                        if (open_we)
                            valid_reg[free_idx_reg] <= 1'b1;
                        if (close_now)
                            valid_reg[hit_idx_reg] <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`include "tcp_connection_tracker_assert.svh"

    `TCT_ASSERT_NEXT(a_act_emits, act_fire, out_valid_reg, "result not presented after act")
    `TCT_ASSERT_NEXT(a_conn_only_act, !act_fire, $stable(conn_cnt_reg), "connection count moved outside act")
    `TCT_ASSERT_NEXT(a_one_open, 1'b1, $countones(valid_reg) <= $past($countones(valid_reg)) + 1, "more than one entry opened")
    `TCT_ASSERT_SAME(a_pop_idle, pop, state_reg == ST_IDLE, "queue popped while busy")

endmodule
